[rtl/random_delay_led_twinkler_defines.svh]
// Assertion helpers for the twinkler RTL.
`ifndef RANDOM_DELAY_LED_TWINKLER_DEFINES_SVH
`define RANDOM_DELAY_LED_TWINKLER_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define RDLT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RDLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rdlt_pkg.sv]
`default_nettype none

package rdlt_pkg;

    // Geometry
    localparam int CHANNELS = 7;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int SEQ_LEN  = 19;
    localparam int SEQ_W    = 5;
    localparam int ROWS     = 4;
    localparam int ROW_W    = 2;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 7;
    localparam int CMD_W    = 8;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // Command byte codes (ASCII)
    localparam logic [CMD_W-1:0] CMD_ON_FIRST   = 8'h31; // '1'
    localparam logic [CMD_W-1:0] CMD_ON_LAST    = CMD_ON_FIRST + CMD_W'(CHANNELS - 1);
    localparam logic [CMD_W-1:0] CMD_OFF_FIRST  = 8'h41; // 'A'
    localparam logic [CMD_W-1:0] CMD_OFF_LAST   = CMD_OFF_FIRST + CMD_W'(CHANNELS - 1);
    localparam logic [CMD_W-1:0] CMD_ROW_STEP_A = 8'h38; // '8'
    localparam logic [CMD_W-1:0] CMD_ROW_STEP_B = 8'h48; // 'H'
    localparam logic [CMD_W-1:0] CMD_ALL_ON     = 8'h39; // '9'
    localparam logic [CMD_W-1:0] CMD_ALL_OFF    = 8'h49; // 'I'

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Delay selection handed to the deadline step
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [SEQ_W-1:0] seq;
    } t_seq_ctl;

    // Delay rows; the last two entries of every row are zero
    localparam logic [DELAY_W-1:0] DELAY_TABLE [0:ROWS-1][0:SEQ_LEN-1] = '{
        '{7'd12, 7'd12, 7'd3,  7'd16, 7'd8,  7'd20, 7'd4,  7'd3,  7'd15, 7'd1,
          7'd15, 7'd4,  7'd6,  7'd15, 7'd19, 7'd9,  7'd10, 7'd0,  7'd0},
        '{7'd12, 7'd12, 7'd3,  7'd16, 7'd8,  7'd50, 7'd4,  7'd3,  7'd15, 7'd100,
          7'd15, 7'd4,  7'd6,  7'd15, 7'd19, 7'd9,  7'd10, 7'd0,  7'd0},
        '{7'd23, 7'd22, 7'd2,  7'd11, 7'd13, 7'd28, 7'd25, 7'd1,  7'd29, 7'd16,
          7'd9,  7'd7,  7'd17, 7'd16, 7'd13, 7'd21, 7'd18, 7'd0,  7'd0},
        '{7'd30, 7'd8,  7'd31, 7'd5,  7'd24, 7'd23, 7'd33, 7'd24, 7'd18, 7'd35,
          7'd30, 7'd23, 7'd29, 7'd1,  7'd22, 7'd24, 7'd25, 7'd0,  7'd0}
    };

    function automatic logic [DELAY_W-1:0] delay_entry(
        input logic [ROW_W-1:0] row,
        input logic [SEQ_W-1:0] idx
    );
        logic [DELAY_W-1:0] d;
        if (idx < SEQ_W'(SEQ_LEN)) begin
            d = DELAY_TABLE[row][idx];
        end else begin
            d = '0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/rdlt_delay_step.sv]
`default_nettype none

// Next deadline of a toggling channel and the advanced sequence index.
module rdlt_delay_step (
    input  wire rdlt_pkg::t_seq_ctl                  i_ctl,
    input  wire logic [rdlt_pkg::TIME_W-1:0]         i_time,
    output logic      [rdlt_pkg::TIME_W-1:0]         o_deadline,
    output logic      [rdlt_pkg::SEQ_W-1:0]          o_seq_next
);

    logic [rdlt_pkg::DELAY_W-1:0] delay;

    // Look up the delay and add it to the time
    assign delay      = rdlt_pkg::delay_entry(i_ctl.row, i_ctl.seq);
    assign o_deadline = i_time + rdlt_pkg::TIME_W'(delay);

    // Advance the shared index, wrap at the sequence length
    assign o_seq_next = (i_ctl.seq >= rdlt_pkg::SEQ_W'(rdlt_pkg::SEQ_LEN - 1))
                        ? '0 : i_ctl.seq + 1'b1;

endmodule

`default_nettype wire

[rtl/random_delay_led_twinkler.sv]
// Seven-channel LED twinkler with pseudo-random toggle delays.
// Input channel: i_in_valid / o_in_stall carry one beat of i_operation and
// i_command_byte. A tick beat (operation 0) advances the millisecond counter
// and scans all channels; a command beat (operation 1) switches channels on
// or off or steps the delay row. Unknown command bytes change nothing.
// Output channel: o_out_valid / i_out_stall carry one beat per input beat with
// the LED levels and the selected delay row after that beat.
// Sequencing: a tick moves from idle to the scan state, which takes the
// channels in turn through the deadline memory's read-compare-write loop,
// and from there to the done state, which loads the result; all-on moves via
// the sweep state, which rewrites every deadline one memory entry per cycle,
// and other commands go straight to the done state. The input stalls until
// the result is loaded, so no beat is taken while another is in work, but one
// is taken while the last result still sits unclaimed in the output register.
// When the receiver stalls, the result holds, and a finished next beat waits
// until the output register frees up.
// Reset (synchronous, active low) clears time, enables, LEDs, sequence index
// and row; deadlines need no clearing since enabling a channel writes one.
`default_nettype none

`include "random_delay_led_twinkler_defines.svh"

module random_delay_led_twinkler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_operation,
    input  wire logic [rdlt_pkg::CMD_W-1:0]         i_command_byte,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [rdlt_pkg::CHANNELS-1:0]      o_led_levels,
    output logic      [rdlt_pkg::ROW_W-1:0]         o_delay_row
);

    localparam int CH_W = rdlt_pkg::CH_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(rdlt_pkg::CHANNELS - 1);

    rdlt_pkg::t_state r_state, n_state;

    logic [rdlt_pkg::TIME_W-1:0]   r_time, n_time;
    logic [rdlt_pkg::CHANNELS-1:0] r_en, n_en;
    logic [rdlt_pkg::CHANNELS-1:0] r_leds, n_leds;
    logic [rdlt_pkg::SEQ_W-1:0]    r_seq, n_seq;
    logic [rdlt_pkg::ROW_W-1:0]    r_row, n_row;
    logic [CH_W-1:0]               r_ch, n_ch;

    logic                          r_out_valid, n_out_valid;
    logic [rdlt_pkg::CHANNELS-1:0] r_out_leds;
    logic [rdlt_pkg::ROW_W-1:0]    r_out_row;
    logic                          out_load;

    // Deadline memory
    logic [rdlt_pkg::TIME_W-1:0] r_deadline_mem [0:rdlt_pkg::CHANNELS-1];
    logic [rdlt_pkg::TIME_W-1:0] r_rdata;
    logic                        mem_we;
    logic [CH_W-1:0]             mem_wa;
    logic [rdlt_pkg::TIME_W-1:0] mem_wd;
    logic [CH_W-1:0]             mem_ra;

    logic [CH_W-1:0]             on_idx;
    logic [CH_W-1:0]             off_idx;
    logic                        hit;

    rdlt_pkg::t_seq_ctl          seq_ctl;
    logic [rdlt_pkg::TIME_W-1:0] new_deadline;
    logic [rdlt_pkg::SEQ_W-1:0]  seq_next;

    assign on_idx  = CH_W'(i_command_byte - rdlt_pkg::CMD_ON_FIRST);
    assign off_idx = CH_W'(i_command_byte - rdlt_pkg::CMD_OFF_FIRST);

    assign seq_ctl.row = r_row;
    assign seq_ctl.seq = r_seq;

    rdlt_delay_step u_delay_step (
        .i_ctl      (seq_ctl),
        .i_time     (r_time),
        .o_deadline (new_deadline),
        .o_seq_next (seq_next)
    );

    // Enabled channel past its deadline toggles
    assign hit = r_en[r_ch] && (r_time > r_rdata);

    // Next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_time   = r_time;
        n_en     = r_en;
        n_leds   = r_leds;
        n_seq    = r_seq;
        n_row    = r_row;
        n_ch     = r_ch;
        mem_we   = 1'b0;
        mem_wa   = r_ch;
        mem_wd   = r_time;
        mem_ra   = '0;
        out_load = 1'b0;
        unique case (r_state)
            rdlt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == rdlt_pkg::OP_TICK) begin
                        n_time  = r_time + 1'b1;
                        n_ch    = '0;
                        mem_ra  = '0;
                        n_state = rdlt_pkg::ST_SCAN;
                    end else begin
                        n_state = rdlt_pkg::ST_DONE;
                        if (i_command_byte >= rdlt_pkg::CMD_ON_FIRST &&
                            i_command_byte <= rdlt_pkg::CMD_ON_LAST) begin
                            n_leds[on_idx] = 1'b1;
                            n_en[on_idx]   = 1'b1;
                            mem_we         = 1'b1;
                            mem_wa         = on_idx;
                        end else if (i_command_byte >= rdlt_pkg::CMD_OFF_FIRST &&
                                     i_command_byte <= rdlt_pkg::CMD_OFF_LAST) begin
                            n_leds[off_idx] = 1'b0;
                            n_en[off_idx]   = 1'b0;
                        end else if (i_command_byte == rdlt_pkg::CMD_ROW_STEP_A ||
                                     i_command_byte == rdlt_pkg::CMD_ROW_STEP_B) begin
                            n_row = (r_row >= rdlt_pkg::ROW_W'(rdlt_pkg::ROWS - 1))
                                    ? '0 : r_row + 1'b1;
                        end else if (i_command_byte == rdlt_pkg::CMD_ALL_ON) begin
                            n_leds  = '1;
                            n_en    = '1;
                            n_ch    = '0;
                            n_state = rdlt_pkg::ST_SWEEP;
                        end else if (i_command_byte == rdlt_pkg::CMD_ALL_OFF) begin
                            n_leds = '0;
                            n_en   = '0;
                        end
                    end
                end
            end
            rdlt_pkg::ST_SCAN: begin
                // Compare the returned deadline, prefetch the next channel
                mem_ra = (r_ch == LAST_CH) ? '0 : r_ch + 1'b1;
                if (hit) begin
                    mem_we       = 1'b1;
                    mem_wd       = new_deadline;
                    n_seq        = seq_next;
                    n_leds[r_ch] = ~r_leds[r_ch];
                end
                if (r_ch == LAST_CH) begin
                    n_state = rdlt_pkg::ST_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            rdlt_pkg::ST_SWEEP: begin
                // Rewrite every deadline with the current time
                mem_we = 1'b1;
                if (r_ch == LAST_CH) begin
                    n_state = rdlt_pkg::ST_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            rdlt_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = rdlt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rdlt_pkg::ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load | (r_out_valid & i_out_stall);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdlt_pkg::ST_IDLE;
            r_time      <= '0;
            r_en        <= '0;
            r_leds      <= '0;
            r_seq       <= '0;
            r_row       <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_en        <= n_en;
            r_leds      <= n_leds;
            r_seq       <= n_seq;
            r_row       <= n_row;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_leds <= r_leds;
            r_out_row  <= r_row;
        end
    end

    // Deadline memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_deadline_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_deadline_mem[mem_ra];
    end

    assign o_in_stall   = (r_state != rdlt_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_led_levels = r_out_leds;
    assign o_delay_row  = r_out_row;

    // Checks
    `RDLT_ASSERT_ALWAYS(a_led_needs_enable, i_clk, i_rst_n, (r_leds & ~r_en) == '0, "LED lit on disabled channel")
    `RDLT_ASSERT_ALWAYS(a_seq_in_range, i_clk, i_rst_n, r_seq < rdlt_pkg::SEQ_W'(rdlt_pkg::SEQ_LEN), "sequence index out of range")
    `RDLT_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, r_state == rdlt_pkg::ST_SCAN && r_ch == LAST_CH, r_state == rdlt_pkg::ST_DONE, "scan did not finish after last channel")
    `RDLT_ASSERT_NEXT(a_done_waits, i_clk, i_rst_n, r_state == rdlt_pkg::ST_DONE && r_out_valid && i_out_stall, r_state == rdlt_pkg::ST_DONE && r_out_valid, "finished result overwrote pending beat")

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rdlt_pkg::*;

    localparam int RANDOM_BEATS = 1800;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic              op;
        logic [CMD_W-1:0]  cb;
    } t_beat;

    typedef struct {
        logic [CHANNELS-1:0] leds;
        logic [ROW_W-1:0]    row;
    } t_led_result;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_op = OP_TICK;
    logic [CMD_W-1:0]    in_cmd = '0;
    logic                out_stall = 1'b0;
    wire                 in_stall;
    wire                 out_valid;
    wire [CHANNELS-1:0]  led_levels;
    wire [ROW_W-1:0]     delay_row;

    t_beat       pending_beats[$];
    t_led_result expected_leds[$];
    int          error_count = 0;

    // Sender burst shaping
    int          burst_left = 1;
    int          gap_left = 0;

    // Receiver stall shaping
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_period = 4;
    int          stall_phase = 0;

    // Predictor state
    logic [TIME_W-1:0]   now_ms = '0;
    bit                  chan_live [CHANNELS];
    logic [TIME_W-1:0]   chan_due [CHANNELS];
    logic [CHANNELS-1:0] led_state = '0;
    int                  seq_pos = 0;
    logic [ROW_W-1:0]    sel_row = '0;

    int unsigned toggle_delay [ROWS][SEQ_LEN] = '{
        '{12, 12, 3, 16, 8, 20, 4, 3, 15, 1, 15, 4, 6, 15, 19, 9, 10, 0, 0},
        '{12, 12, 3, 16, 8, 50, 4, 3, 15, 100, 15, 4, 6, 15, 19, 9, 10, 0, 0},
        '{23, 22, 2, 11, 13, 28, 25, 1, 29, 16, 9, 7, 17, 16, 13, 21, 18, 0, 0},
        '{30, 8, 31, 5, 24, 23, 33, 24, 18, 35, 30, 23, 29, 1, 22, 24, 25, 0, 0}
    };

    random_delay_led_twinkler DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_command_byte (in_cmd),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_led_levels   (led_levels),
        .o_delay_row    (delay_row)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_beat(input logic op, input logic [CMD_W-1:0] cb);
        t_beat b;
        b.op = op;
        b.cb = cb;
        pending_beats.push_back(b);
    endtask

    function automatic void switch_channel(input int k, input bit on);
        chan_live[k] = on;
        led_state[k] = on;
        if (on) begin
            chan_due[k] = now_ms;
        end
    endfunction

    // Advance the model by one beat and return the levels it should report
    function automatic t_led_result predict_leds(input logic op, input logic [CMD_W-1:0] cb);
        t_led_result r;
        int k;
        if (op == OP_TICK) begin
            now_ms = now_ms + 1'b1;
            for (k = 0; k < CHANNELS; k++) begin
                if (chan_live[k] && now_ms > chan_due[k]) begin
                    chan_due[k] = now_ms + TIME_W'(toggle_delay[sel_row][seq_pos]);
                    seq_pos = (seq_pos == SEQ_LEN - 1) ? 0 : seq_pos + 1;
                    led_state[k] = ~led_state[k];
                end
            end
        end else if (cb >= CMD_ON_FIRST && cb <= CMD_ON_LAST) begin
            switch_channel(int'(cb - CMD_ON_FIRST), 1'b1);
        end else if (cb >= CMD_OFF_FIRST && cb <= CMD_OFF_LAST) begin
            switch_channel(int'(cb - CMD_OFF_FIRST), 1'b0);
        end else if (cb == CMD_ROW_STEP_A || cb == CMD_ROW_STEP_B) begin
            sel_row = (int'(sel_row) == ROWS - 1) ? '0 : sel_row + 1'b1;
        end else if (cb == CMD_ALL_ON || cb == CMD_ALL_OFF) begin
            for (k = 0; k < CHANNELS; k++) begin
                switch_channel(k, cb == CMD_ALL_ON);
            end
        end
        r.leds = led_state;
        r.row  = sel_row;
        return r;
    endfunction

    // Drive input beats in bursts; predict each beat as it is accepted
    always @(posedge clk) begin
        t_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_leds.push_back(predict_leds(in_op, in_cmd));
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    nxt = pending_beats.pop_front();
                    in_op    <= nxt.op;
                    in_cmd   <= nxt.cb;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the output on a shifting pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode   <= t_stall_mode'($urandom_range(0, 3));
                mode_left    <= $urandom_range(20, 200);
                stall_period <= $urandom_range(2, 7);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE: begin
                    out_stall <= 1'b0;
                end
                STALL_RANDOM: begin
                    out_stall <= ($urandom_range(0, 99) < 30);
                end
                STALL_PERIODIC: begin
                    out_stall <= ((stall_phase % stall_period) < 2);
                end
                default: begin
                    out_stall <= ($urandom_range(0, 99) < 75);
                end
            endcase
            stall_phase <= stall_phase + 1;
        end
    end

    // Check each output beat against the oldest expectation
    always @(posedge clk) begin
        t_led_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_leds.size() == 0) begin
                report_mismatch($sformatf("unexpected beat leds=%b row=%0d",
                                          led_levels, delay_row));
            end else begin
                want = expected_leds.pop_front();
                if (led_levels !== want.leds) begin
                    report_mismatch($sformatf("led_levels got %b want %b",
                                              led_levels, want.leds));
                end
                if (delay_row !== want.row) begin
                    report_mismatch($sformatf("delay_row got %0d want %0d",
                                              delay_row, want.row));
                end
            end
        end
    end

    // Build the stimulus, release reset, wait for the drain
    initial begin
        t_beat b;
        int n;
        int pick;
        for (n = 0; n < CHANNELS; n++) begin
            chan_live[n] = 1'b0;
            chan_due[n]  = '0;
        end

        // Unknown bytes at the extremes, and a command byte riding on a tick
        add_beat(OP_CMD, 8'h00);
        add_beat(OP_CMD, 8'hFF);
        add_beat(OP_TICK, CMD_ALL_ON);
        // Channel on holds its level until the next tick moves past it
        add_beat(OP_CMD, CMD_ON_FIRST);
        add_beat(OP_TICK, 8'hFF);
        add_beat(OP_CMD, CMD_ON_LAST);
        add_beat(OP_CMD, CMD_OFF_LAST);
        add_beat(OP_CMD, CMD_OFF_FIRST);
        // Bytes just outside the command ranges
        add_beat(OP_CMD, CMD_ON_FIRST - 1'b1);
        add_beat(OP_CMD, CMD_ALL_ON + 1'b1);
        add_beat(OP_CMD, CMD_OFF_FIRST - 1'b1);
        add_beat(OP_CMD, CMD_ALL_OFF + 1'b1);
        // Step the row through a full wrap with both codes
        add_beat(OP_CMD, CMD_ROW_STEP_A);
        add_beat(OP_CMD, CMD_ROW_STEP_B);
        add_beat(OP_CMD, CMD_ROW_STEP_A);
        add_beat(OP_CMD, CMD_ROW_STEP_B);
        // All on, then advance the sequence with ticks on either side of a row step
        add_beat(OP_CMD, CMD_ALL_ON);
        for (n = 0; n < 4; n++) begin
            add_beat(OP_TICK, CMD_W'($urandom_range(0, 255)));
        end
        add_beat(OP_CMD, CMD_ROW_STEP_A);
        for (n = 0; n < 3; n++) begin
            add_beat(OP_TICK, CMD_W'($urandom_range(0, 255)));
        end
        add_beat(OP_CMD, CMD_ALL_OFF);
        add_beat(OP_TICK, 8'h00);

        // Random mix weighted toward ticks and channel switching
        for (n = 0; n < RANDOM_BEATS; n++) begin
            b.cb = CMD_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 62) begin
                b.op = OP_TICK;
            end else begin
                b.op = OP_CMD;
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    b.cb = CMD_ON_FIRST + CMD_W'($urandom_range(0, CHANNELS - 1));
                end else if (pick < 45) begin
                    b.cb = CMD_OFF_FIRST + CMD_W'($urandom_range(0, CHANNELS - 1));
                end else if (pick < 52) begin
                    b.cb = CMD_ROW_STEP_A;
                end else if (pick < 59) begin
                    b.cb = CMD_ROW_STEP_B;
                end else if (pick < 66) begin
                    b.cb = CMD_ALL_ON;
                end else if (pick < 70) begin
                    b.cb = CMD_ALL_OFF;
                end
            end
            pending_beats.push_back(b);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_valid || expected_leds.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
